// File: rtl/lshq_pkg.sv
// lshq_pkg: shared constants, state and control types for the lsh projection quantizer
// used by lshq_mac, lshq_quant and lsh_projection_quantizer; depends on nothing

package lshq_pkg;

    localparam int NUM_PLANES_DEF   = 16;
    localparam int MAX_FEATURES_DEF = 256;
    localparam int PLANE_SLOTS      = 16;

    localparam int CODE_W       = 8;
    localparam int COEF_W       = 16;
    localparam int FEAT_W       = 17;
    localparam int FIDX_FIELD_W = 8;
    localparam int PLANE_W      = 4;
    localparam int CW_W         = 32;
    localparam int MCAND_W      = COEF_W + FEAT_W;

    localparam logic [CW_W-1:0] CW_RESET = 32'h0001_0000;

    // s_tdata layout, lowest bit first
    localparam int PLANE_LSB   = 0;
    localparam int FIDX_LSB    = PLANE_LSB + PLANE_W;
    localparam int COEF_LSB    = FIDX_LSB + FIDX_FIELD_W;
    localparam int FEAT_LSB    = COEF_LSB + COEF_W;
    localparam int S_FIELDS_W  = FEAT_LSB + FEAT_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = PLANE_SLOTS * CODE_W;

    // serial divider: one quotient bit per cycle
    localparam int QUOT_BITS = 9;
    localparam int QCNT_W    = 4;
    localparam int POS_LIM   = 127;
    localparam int NEG_LIM   = 128;

    localparam logic [CODE_W-1:0] CODE_POS_MAX = 8'h7F;
    localparam logic [CODE_W-1:0] CODE_NEG_MAX = 8'h80;

    localparam logic ACT_COEF = 1'b0;
    localparam logic ACT_FEAT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_QSTART,
        ST_QWAIT,
        ST_DONE
    } lshq_state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic add;
        logic clear;
    } lshq_mac_ctl_t;

    typedef struct packed {
        logic              done;
        logic [CODE_W-1:0] code;
        logic              sat;
    } lshq_quant_res_t;

endpackage

// File: rtl/lshq_mac.sv
// lshq_mac: one hyperplane, coefficient memory and bit-serial multiply-accumulate
// depends on lshq_pkg

module lshq_mac import lshq_pkg::*; #(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int ACC_W        = 42,
    localparam int ADDR_W      = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lshq_mac_ctl_t           ctl,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       addr,
    input  logic [COEF_W-1:0]       wr_data,
    output logic signed [ACC_W-1:0] acc
);

    logic [COEF_W-1:0]         mem_reg [MAX_FEATURES];
    logic signed [MCAND_W-1:0] mcand_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[addr] <= wr_data;
        end
        if (ctl.load) begin
            mcand_reg <= MCAND_W'(signed'(mem_reg[addr]));
        end else if (ctl.shift) begin
            mcand_reg <= mcand_reg <<< 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctl.clear) begin
            acc_reg <= '0;
        end else if (ctl.add) begin
            acc_reg <= acc_reg + ACC_W'(mcand_reg);
        end
    end

    assign acc = acc_reg;

endmodule

// File: rtl/lshq_quant.sv
// lshq_quant: serial restoring divider, trunc(2*|acc| / cell_width) clamped to a signed byte
// depends on lshq_pkg

module lshq_quant import lshq_pkg::*; #(
    parameter int ACC_W = 42
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] acc,
    input  logic [CW_W-1:0]         cell_width,
    output lshq_quant_res_t         res
);

    localparam int NUM_W = ACC_W + 1;
    localparam int DIV_W = CW_W + QUOT_BITS - 1;
    localparam int CMP_W = (NUM_W > DIV_W) ? NUM_W : DIV_W;

    logic                 busy_reg;
    logic [QCNT_W-1:0]    cnt_reg;
    logic [CMP_W-1:0]     rem_reg;
    logic [CMP_W-1:0]     dsh_reg;
    logic [QUOT_BITS-1:0] q_reg;
    logic                 neg_reg;
    logic                 zero_reg;
    lshq_quant_res_t      res_reg;

    logic [ACC_W-1:0]     mag;
    logic                 ge;
    logic [CMP_W-1:0]     diff;
    logic [QUOT_BITS-1:0] q_next;
    logic [CODE_W-1:0]    code;
    logic                 sat;

    assign mag    = acc[ACC_W-1] ? ACC_W'(~acc + 1'b1) : ACC_W'(acc);
    assign ge     = (rem_reg >= dsh_reg);
    assign diff   = rem_reg - dsh_reg;
    assign q_next = {q_reg[QUOT_BITS-2:0], ge};

    always_comb begin
        code = '0;
        sat  = 1'b0;
        if (zero_reg) begin
            code = '0;
        end else if (neg_reg) begin
            if (q_next > QUOT_BITS'(NEG_LIM)) begin
                code = CODE_NEG_MAX;
                sat  = 1'b1;
            end else begin
                code = CODE_W'(~q_next[CODE_W-1:0] + 1'b1);
            end
        end else begin
            if (q_next > QUOT_BITS'(POS_LIM)) begin
                code = CODE_POS_MAX;
                sat  = 1'b1;
            end else begin
                code = q_next[CODE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            res_reg  <= '0;
        end else begin
            res_reg.done <= busy_reg && !start && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= QCNT_W'(QUOT_BITS - 1);
                rem_reg  <= CMP_W'({mag, 1'b0});
                dsh_reg  <= CMP_W'({cell_width, {(QUOT_BITS-1){1'b0}}});
                q_reg    <= '0;
                neg_reg  <= acc[ACC_W-1];
                zero_reg <= (acc == '0);
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= diff;
                end
                q_reg   <= q_next;
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg     <= 1'b0;
                    res_reg.code <= code;
                    res_reg.sat  <= sat;
                end
            end
        end
    end

    assign res = res_reg;

endmodule

// File: rtl/lsh_projection_quantizer.sv
// lsh_projection_quantizer: random-projection hash codes for a stream of point features
// depends on lshq_pkg, lshq_mac and lshq_quant
//
//   port group   dir  fields (lowest bit first)
//   s_*          in   tdata: plane, feature_index, coefficient, feature; tuser: action;
//                     tlast: last
//   m_*          out  tdata: codes_low, codes_high; tuser: saturated
//   cfg_*        in   wdata: cell_width
//
// a coefficient item is written into the coefficient memory of its plane; a feature
// item loads the multiplicand, then the bit-serial multiply-accumulate in each plane
// works through the feature bits. on a last feature the shared serial divider runs
// each plane in turn, then the output register is loaded. s_tready is low while an
// item is in work; a stalled result holds in the output register, and only the next
// finished point waits for it. reset clears the accumulators and sets cell_width to
// 1.0; the coefficient memory is not cleared.

module lsh_projection_quantizer import lshq_pkg::*; #(
    parameter int NUM_PLANES   = NUM_PLANES_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [CW_W-1:0]      cfg_wdata,    // cell_width
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // plane, feature_index, coefficient, feature
    input  logic                 s_tuser,      // action
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // codes_low, codes_high
    output logic                 m_tuser       // saturated
);

    localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int ACC_W  = MCAND_W + 1 + $clog2(MAX_FEATURES);

    lshq_state_t          state_reg, state_next;
    logic [CW_W-1:0]      cw_reg;
    logic [FEAT_W-1:0]    feat_reg, feat_next;
    logic                 last_reg, last_next;
    logic [PIDX_W-1:0]    pidx_reg, pidx_next;
    logic                 sat_reg, sat_next;
    logic [CODE_W-1:0]    codes_reg [NUM_PLANES];
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic [PLANE_W-1:0]      s_plane;
    logic [FIDX_FIELD_W-1:0] s_fidx;
    logic [COEF_W-1:0]       s_coef;
    logic [FEAT_W-1:0]       s_feat;
    logic                    accept;
    logic                    fidx_ok;
    logic [ADDR_W-1:0]       addr;
    logic [NUM_PLANES-1:0]   wr_en;
    logic signed [ACC_W-1:0] acc_w [NUM_PLANES];
    lshq_mac_ctl_t           mac_ctl;
    logic                    q_start;
    lshq_quant_res_t         q_res;
    logic                    code_wr;
    logic                    out_load;
    logic [M_TDATA_W-1:0]    codes_flat;

    assign s_plane = s_tdata[PLANE_LSB +: PLANE_W];
    assign s_fidx  = s_tdata[FIDX_LSB +: FIDX_FIELD_W];
    assign s_coef  = s_tdata[COEF_LSB +: COEF_W];
    assign s_feat  = s_tdata[FEAT_LSB +: FEAT_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fidx_ok  = (int'(s_fidx) < MAX_FEATURES);
    assign addr     = ADDR_W'(s_fidx);

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        assign wr_en[p] = accept && (s_tuser == ACT_COEF) && fidx_ok
                          && (s_plane == PLANE_W'(p));

        lshq_mac #(
            .MAX_FEATURES (MAX_FEATURES),
            .ACC_W        (ACC_W)
        ) u_mac (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (mac_ctl),
            .wr_en   (wr_en[p]),
            .addr    (addr),
            .wr_data (s_coef),
            .acc     (acc_w[p])
        );
    end

    lshq_quant #(
        .ACC_W (ACC_W)
    ) u_quant (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (q_start),
        .acc        (acc_w[pidx_reg]),
        .cell_width (cw_reg),
        .res        (q_res)
    );

    for (genvar s = 0; s < PLANE_SLOTS; s++) begin : g_slot
        if (s < NUM_PLANES) begin : g_used
            assign codes_flat[s*CODE_W +: CODE_W] = codes_reg[s];
        end else begin : g_unused
            assign codes_flat[s*CODE_W +: CODE_W] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cw_reg       <= CW_RESET;
            pidx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pidx_reg     <= pidx_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen) begin
                cw_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        feat_reg <= feat_next;
        last_reg <= last_next;
        sat_reg  <= sat_next;
        if (code_wr) begin
            codes_reg[pidx_reg] <= q_res.code;
        end
        if (out_load) begin
            m_tdata_reg <= codes_flat;
            m_tuser_reg <= sat_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        feat_next  = feat_reg;
        last_next  = last_reg;
        pidx_next  = pidx_reg;
        sat_next   = sat_reg;
        mac_ctl    = '0;
        q_start    = 1'b0;
        code_wr    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == ACT_FEAT)) begin
                    mac_ctl.load = 1'b1;
                    feat_next    = fidx_ok ? s_feat : '0;
                    last_next    = s_tlast;
                    pidx_next    = '0;
                    sat_next     = 1'b0;
                    state_next   = ST_MAC;
                end
            end
            ST_MAC: begin
                mac_ctl.shift = 1'b1;
                mac_ctl.add   = feat_reg[0];
                feat_next     = feat_reg >> 1;
                if (feat_reg[FEAT_W-1:1] == '0) begin
                    state_next = last_reg ? ST_QSTART : ST_IDLE;
                end
            end
            ST_QSTART: begin
                q_start    = 1'b1;
                state_next = ST_QWAIT;
            end
            ST_QWAIT: begin
                if (q_res.done) begin
                    code_wr  = 1'b1;
                    sat_next = sat_reg | q_res.sat;
                    if (pidx_reg == PIDX_W'(NUM_PLANES - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        pidx_next  = pidx_reg + 1'b1;
                        state_next = ST_QSTART;
                    end
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    mac_ctl.clear = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = out_load | (m_tvalid_reg & ~m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        q_res.done |-> (state_reg == ST_QWAIT))
        else $error("divider finished outside its wait state");

    a_pidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pidx_reg <= PIDX_W'(NUM_PLANES - 1))
        else $error("plane index beyond the last plane");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (acc_w[0] == '0))
        else $error("accumulator not cleared after a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !out_load)
        else $error("pending result overwritten");

endmodule
